// ===== hdl/pnt_pkg.sv =====
// Package for the Petri net transition firing engine: sizes, codes and shared types.
// No dependencies; pnt_alu, the top level and the testbench import it.
package pnt_pkg;

  localparam int NUM_PLACES      = 20;
  localparam int NUM_TRANSITIONS = 40;
  localparam int TOKEN_BITS      = 8;
  localparam int WEIGHT_BITS     = 8;

  localparam int ARC_COUNT = NUM_PLACES * NUM_TRANSITIONS;
  localparam int ARC_AW    = $clog2(ARC_COUNT);
  localparam int PLACE_AW  = $clog2(NUM_PLACES);
  localparam int PLACE_CW  = $clog2(NUM_PLACES + 1);

  // working width for token math: wide enough for either operand plus a borrow bit
  localparam int CALC_W = ((TOKEN_BITS > WEIGHT_BITS) ? TOKEN_BITS : WEIGHT_BITS) + 1;
  localparam logic [CALC_W-1:0] TOKEN_MAX = CALC_W'((1 << TOKEN_BITS) - 1);

  typedef logic [TOKEN_BITS-1:0]  token_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;

  // request codes
  localparam logic [2:0] ACT_FIRE   = 3'd0;
  localparam logic [2:0] ACT_WR_IN  = 3'd1;
  localparam logic [2:0] ACT_WR_OUT = 3'd2;
  localparam logic [2:0] ACT_SET    = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_FIRED   = 2'd0;
  localparam logic [1:0] ST_NOT_EN  = 2'd1;
  localparam logic [1:0] ST_WR_DONE = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  typedef struct packed {
    logic   borrow;       // tokens below input weight
    token_t next_tokens;  // tokens - w_in + w_out, saturated
  } alu_res_t;

endpackage

// ===== hdl/pnt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pnt_alu.sv =====
// Shared token unit: enable check (borrow) and saturating marking update.
// Depends on pnt_pkg.
module pnt_alu
  import pnt_pkg::*;
(
  input  token_t   tokens,
  input  weight_t  w_in,
  input  weight_t  w_out,
  output alu_res_t res
);

  logic [CALC_W-1:0] diff;
  logic [CALC_W-1:0] sum;

  always_comb begin
    diff = CALC_W'(tokens) - CALC_W'(w_in);
    sum  = diff + CALC_W'(w_out);
    res.borrow = diff[CALC_W-1];
    // sum only meaningful without borrow; then it fits in CALC_W
    res.next_tokens = (sum > TOKEN_MAX) ? TOKEN_MAX[TOKEN_BITS-1:0] : sum[TOKEN_BITS-1:0];
  end

endmodule

// ===== hdl/petri_net_transition_firing_top.sv =====
// Petri net transition firing engine, top level: sequencer, marking, weight RAMs.
// Depends on pnt_pkg, pnt_ram and pnt_alu.
//
// Usage:
//   Input words (in_valid/in_ready) carry action, transition, place, value.
//   Every accepted word yields exactly one result word (out_valid/out_ready)
//   with fired, status and tokens.
//   Weight writes, token set/read and unknown actions do their work when the
//   word is accepted; the result is then posted from the result state.
//   A fire runs two passes over the places through one shared compare/add
//   unit, fed by the registered-read weight RAMs: a check pass, then an
//   update pass, then the result is posted from the result state.
//   A fire that fails the check stops early at the first short place.
//   in_ready is high only while the sequencer is idle: one word at a time,
//   so no new word is taken until the last one's result has been posted.
//   A result parked in the output register does not block acceptance of the
//   next word; the sequencer waits in its result state while a parked result is not yet taken.
//   Reset: marking goes to one token in place 0, zero elsewhere. Both weight
//   RAMs are then cleared by a pass over all NUM_TRANSITIONS*NUM_PLACES
//   entries, one entry per cycle; in_ready stays low during that pass.
module petri_net_transition_firing_top
  import pnt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [5:0] in_transition,
  input  logic [4:0] in_place,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_fired,
  output logic [1:0] out_status,
  output logic [7:0] out_tokens
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_UPDATE,
    S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [ARC_AW-1:0]   addr_r, addr_nxt;     // clear sweep / pass read address
  logic [ARC_AW-1:0]   base_r, base_nxt;     // row start of the transition being fired
  logic [PLACE_CW-1:0] cnt_r, cnt_nxt;       // pass step, 0..NUM_PLACES
  logic                res_fired_r, res_fired_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [7:0]          res_tokens_r, res_tokens_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_fired_r, out_fired_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [7:0]          out_tokens_r, out_tokens_nxt;

  // marking: small register file, one read and one write address per cycle
  token_t              marking_r [NUM_PLACES];
  logic                mark_we;
  logic [PLACE_AW-1:0] mark_widx;
  token_t              mark_wdata;
  logic [PLACE_AW-1:0] mark_ridx;
  token_t              mark_rdata;

  // weight RAMs share address buses
  logic                iw_we, ow_we;
  logic [ARC_AW-1:0]   w_waddr;
  weight_t             w_wdata;
  logic                w_re;
  weight_t             iw_rdata, ow_rdata;

  alu_res_t            alu_res;

  // request decode
  logic                t_ok, p_ok;
  logic [ARC_AW-1:0]   arc_base, arc_addr;
  logic [PLACE_AW-1:0] in_pidx;
  logic [PLACE_CW-1:0] cnt_m1;
  logic [PLACE_AW-1:0] prev_idx;
  logic                pass_end;
  logic [CALC_W-1:0]   val_ext, tok_ext;
  token_t              set_tokens;

  assign t_ok     = int'(in_transition) < NUM_TRANSITIONS;
  assign p_ok     = int'(in_place) < NUM_PLACES;
  assign arc_base = ARC_AW'(int'(in_transition) * NUM_PLACES);
  assign arc_addr = ARC_AW'(int'(in_transition) * NUM_PLACES + int'(in_place));
  assign in_pidx  = PLACE_AW'(in_place);

  // data arriving this cycle belongs to the place issued one step earlier
  assign cnt_m1   = cnt_r - 1'b1;
  assign prev_idx = cnt_m1[PLACE_AW-1:0];
  assign pass_end = (cnt_r == PLACE_CW'(NUM_PLACES));

  assign val_ext    = CALC_W'(in_value);
  assign set_tokens = (val_ext > TOKEN_MAX) ? TOKEN_MAX[TOKEN_BITS-1:0] : val_ext[TOKEN_BITS-1:0];

  assign mark_ridx  = (state_r == S_IDLE) ? in_pidx : prev_idx;
  assign mark_rdata = marking_r[mark_ridx];
  assign tok_ext    = CALC_W'(mark_rdata);

  assign w_re = ((state_r == S_CHECK) || (state_r == S_UPDATE)) && !pass_end;

  pnt_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ARC_COUNT)) u_iw_ram (
    .clk   (clk),
    .we    (iw_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (addr_r),
    .rdata (iw_rdata)
  );

  pnt_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ARC_COUNT)) u_ow_ram (
    .clk   (clk),
    .we    (ow_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (addr_r),
    .rdata (ow_rdata)
  );

  pnt_alu u_alu (
    .tokens (mark_rdata),
    .w_in   (iw_rdata),
    .w_out  (ow_rdata),
    .res    (alu_res)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    res_fired_nxt  = res_fired_r;
    res_status_nxt = res_status_r;
    res_tokens_nxt = res_tokens_r;
    out_valid_nxt  = out_valid_r;
    out_fired_nxt  = out_fired_r;
    out_status_nxt = out_status_r;
    out_tokens_nxt = out_tokens_r;
    mark_we        = 1'b0;
    mark_widx      = prev_idx;
    mark_wdata     = alu_res.next_tokens;
    iw_we          = 1'b0;
    ow_we          = 1'b0;
    w_waddr        = addr_r;
    w_wdata        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        iw_we    = 1'b1;
        ow_we    = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == ARC_AW'(ARC_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_fired_nxt  = 1'b0;
          res_status_nxt = ST_WR_DONE;
          res_tokens_nxt = '0;
          state_nxt      = S_RESP;
          unique case (in_action)
            ACT_FIRE: begin
              if (t_ok) begin
                base_nxt  = arc_base;
                addr_nxt  = arc_base;
                cnt_nxt   = '0;
                state_nxt = S_CHECK;
              end else begin
                res_status_nxt = ST_NOT_EN;
              end
            end
            ACT_WR_IN: begin
              iw_we   = t_ok && p_ok;
              w_waddr = arc_addr;
              w_wdata = in_value;
            end
            ACT_WR_OUT: begin
              ow_we   = t_ok && p_ok;
              w_waddr = arc_addr;
              w_wdata = in_value;
            end
            ACT_SET: begin
              mark_we    = p_ok;
              mark_widx  = in_pidx;
              mark_wdata = set_tokens;
            end
            ACT_READ: begin
              res_status_nxt = ST_READ;
              res_tokens_nxt = p_ok ? tok_ext[7:0] : 8'd0;
            end
            default: begin
            end
          endcase
        end
      end

      S_CHECK: begin
        addr_nxt = addr_r + 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if ((cnt_r != '0) && alu_res.borrow) begin
          res_status_nxt = ST_NOT_EN;
          state_nxt      = S_RESP;
        end else if (pass_end) begin
          addr_nxt  = base_r;
          cnt_nxt   = '0;
          state_nxt = S_UPDATE;
        end
      end

      S_UPDATE: begin
        addr_nxt = addr_r + 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        mark_we  = (cnt_r != '0);
        if (pass_end) begin
          res_fired_nxt  = 1'b1;
          res_status_nxt = ST_FIRED;
          state_nxt      = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = res_fired_r;
          out_status_nxt = res_status_r;
          out_tokens_nxt = res_tokens_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r       <= base_nxt;
    res_fired_r  <= res_fired_nxt;
    res_status_r <= res_status_nxt;
    res_tokens_r <= res_tokens_nxt;
    out_fired_r  <= out_fired_nxt;
    out_status_r <= out_status_nxt;
    out_tokens_r <= out_tokens_nxt;
  end

  // marking store; place 0 starts with one token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLACES; i++) begin
        marking_r[i] <= (i == 0) ? token_t'(1) : '0;
      end
    end else if (mark_we) begin
      marking_r[mark_widx] <= mark_wdata;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_fired  = out_fired_r;
  assign out_status = out_status_r;
  assign out_tokens = out_tokens_r;

  // a result is only ever posted from the result state
  a_post_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_RESP))
    else $error("result posted outside result state");

  // fired flag and status agree
  a_fired_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fired == (out_status == ST_FIRED)))
    else $error("fired flag disagrees with status");

  // tokens are zero unless the result is a read
  a_tokens_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_READ)) |-> (out_tokens == 8'd0))
    else $error("tokens nonzero on non-read result");

  // pass read address tracks the step counter within the fired row
  a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHECK) || (state_r == S_UPDATE)) |-> (addr_r == base_r + ARC_AW'(cnt_r)))
    else $error("pass address out of step");

endmodule

// ===== sim/petri_net_transition_firing_top_tb.sv =====
// Testbench for the Petri net transition firing engine (petri_net_transition_firing_top).
// Drives request words with random gaps, checks every result word against an in-bench
// marking/weight predictor. Depends on pnt_pkg and the block's RTL only.
module petri_net_transition_firing_top_tb;
  import pnt_pkg::*;

  localparam int TARGET_WORDS = 650;
  localparam int TOKEN_CEIL   = (1 << TOKEN_BITS) - 1;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic       fired;
    logic [1:0] status;
    logic [7:0] tokens;
  } result_t;

  // Predictor and result checker: mirrors the marking and both weight tables,
  // queues one expected result per accepted request word.
  class marking_scoreboard;
    token_t  marks [NUM_PLACES];
    weight_t w_in  [NUM_TRANSITIONS][NUM_PLACES];
    weight_t w_out [NUM_TRANSITIONS][NUM_PLACES];
    result_t expected_q [$];
    int      mismatches;
    int      words_seen;
    int      results_seen;
    int      fires_taken;
    int      fires_blocked;
    int      reads;
    int      writes;

    function new();
      foreach (marks[i]) marks[i] = '0;
      marks[0] = token_t'(1);
      foreach (w_in[t, p]) begin
        w_in[t][p]  = '0;
        w_out[t][p] = '0;
      end
      mismatches    = 0;
      words_seen    = 0;
      results_seen  = 0;
      fires_taken   = 0;
      fires_blocked = 0;
      reads         = 0;
      writes        = 0;
    endfunction

    function void note_word(logic [2:0] act, logic [5:0] t, logic [4:0] p, logic [7:0] v);
      result_t r;
      bit      t_ok;
      bit      p_ok;
      bit      enabled;
      int      sum;
      t_ok = t < NUM_TRANSITIONS;
      p_ok = p < NUM_PLACES;
      r    = '0;
      r.status = ST_WR_DONE;
      words_seen++;
      case (act)
        ACT_FIRE: begin
          enabled = t_ok;
          if (enabled) begin
            for (int i = 0; i < NUM_PLACES; i++)
              if (marks[i] < w_in[t][i]) enabled = 0;
          end
          if (enabled) begin
            // subtract inputs, add outputs, clamp at the token ceiling
            for (int i = 0; i < NUM_PLACES; i++) begin
              sum = int'(marks[i]) - int'(w_in[t][i]) + int'(w_out[t][i]);
              if (sum > TOKEN_CEIL) sum = TOKEN_CEIL;
              marks[i] = token_t'(sum);
            end
            r.fired  = 1'b1;
            r.status = ST_FIRED;
            fires_taken++;
          end else begin
            r.status = ST_NOT_EN;
            fires_blocked++;
          end
        end
        ACT_WR_IN: begin
          if (t_ok && p_ok) w_in[t][p] = weight_t'(v);
          writes++;
        end
        ACT_WR_OUT: begin
          if (t_ok && p_ok) w_out[t][p] = weight_t'(v);
          writes++;
        end
        ACT_SET: begin
          if (p_ok) marks[p] = (int'(v) > TOKEN_CEIL) ? token_t'(TOKEN_CEIL) : token_t'(v);
          writes++;
        end
        ACT_READ: begin
          r.status = ST_READ;
          if (p_ok) r.tokens = 8'(marks[p]);
          reads++;
        end
        default: ;  // unused codes: nothing changes, write-done status
      endcase
      expected_q = {expected_q, r};
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic f, logic [1:0] s, logic [7:0] tk);
      result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d with no request outstanding", results_seen));
      end else begin
        e = expected_q.pop_front();
        if (f !== e.fired)
          report($sformatf("result %0d fired %b, want %b", results_seen, f, e.fired));
        if (s !== e.status)
          report($sformatf("result %0d status %0d, want %0d", results_seen, s, e.status));
        if (tk !== e.tokens)
          report($sformatf("result %0d tokens %0d, want %0d", results_seen, tk, e.tokens));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_action;
  logic [5:0] in_transition;
  logic [4:0] in_place;
  logic [7:0] in_value;
  logic       out_valid;
  logic       out_ready;
  logic       out_fired;
  logic [1:0] out_status;
  logic [7:0] out_tokens;

  marking_scoreboard sb = new();

  bit calm;          // when set, neither side idles
  int useful_words;  // words with a used code and in-range indices

  petri_net_transition_firing_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_transition(in_transition),
    .in_place     (in_place),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_fired    (out_fired),
    .out_status   (out_status),
    .out_tokens   (out_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous ceiling: ~650 words at their worst plus the weight clear.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Monitor: both handshakes sampled at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_fired, out_status, out_tokens);
      if (in_valid && in_ready) sb.note_word(in_action, in_transition, in_place, in_value);
    end
  end

  // Result side: ready runs broken by random stalls.
  initial begin
    int run_len;
    int stall;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // One request word; valid stays up between back-to-back words.
  task automatic send_word(logic [2:0] act, logic [5:0] t, logic [4:0] p, logic [7:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_transition <= t;
    in_place      <= p;
    in_value      <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // out-of-range targets and unused codes leave the net alone
    if (act <= ACT_READ && p < NUM_PLACES &&
        (act == ACT_SET || act == ACT_READ || t < NUM_TRANSITIONS))
      useful_words++;
  endtask

  function automatic logic [5:0] rand_transition();
    if ($urandom_range(0, 19) == 0) return 6'($urandom_range(NUM_TRANSITIONS, 63));
    return 6'($urandom_range(0, NUM_TRANSITIONS - 1));
  endfunction

  function automatic logic [4:0] rand_place();
    if ($urandom_range(0, 19) == 0) return 5'($urandom_range(NUM_PLACES, 31));
    return 5'($urandom_range(0, NUM_PLACES - 1));
  endfunction

  // Weights mostly small so fires go through; a few large ones to hit saturation.
  function automatic logic [7:0] rand_weight();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 3));
  endfunction

  // Noise word: any code, any index, any value.
  task automatic random_word();
    logic [2:0] act;
    if ($urandom_range(0, 99) < 4) act = ACT_READ + 3'($urandom_range(1, 3));
    else act = 3'($urandom_range(ACT_FIRE, ACT_READ));
    send_word(act, rand_transition(), rand_place(), 8'($urandom_range(0, 255)));
  endtask

  // Well-formed scenario: program one transition, load some places, fire, read back.
  task automatic net_sequence();
    logic [5:0] t;
    logic [7:0] tk;
    t = 6'($urandom_range(0, NUM_TRANSITIONS - 1));
    repeat ($urandom_range(0, 4)) send_word(ACT_WR_IN, t, rand_place(), rand_weight());
    repeat ($urandom_range(0, 3)) send_word(ACT_WR_OUT, t, rand_place(), rand_weight());
    repeat ($urandom_range(0, 4)) begin
      tk = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(240, 255))
                                        : 8'($urandom_range(0, 6));
      send_word(ACT_SET, rand_transition(), rand_place(), tk);
    end
    repeat ($urandom_range(1, 3)) send_word(ACT_FIRE, t, rand_place(), 8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 3)) send_word(ACT_READ, rand_transition(), rand_place(), 8'd0);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_FIRE;
    in_transition = '0;
    in_place      = '0;
    in_value      = '0;
    calm          = 1'b0;
    useful_words  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // the first word may come at once; the block holds in_ready low through its weight clear.

    // Directed part: reset marking, empty transition, blocked and saturating fires,
    // out-of-range indices, unused codes, field extremes.
    send_word(ACT_READ,   6'd0,  5'd0,  8'd0);    // reset marking: one token in place 0
    send_word(ACT_READ,   6'd63, 5'd19, 8'd255);
    send_word(ACT_FIRE,   6'd0,  5'd0,  8'd0);    // all-zero weights: always enabled
    send_word(ACT_WR_IN,  6'd1,  5'd0,  8'd2);
    send_word(ACT_FIRE,   6'd1,  5'd0,  8'd0);    // place 0 short by one token
    send_word(ACT_SET,    6'd0,  5'd0,  8'd255);
    send_word(ACT_WR_OUT, 6'd1,  5'd19, 8'd255);
    send_word(ACT_WR_OUT, 6'd1,  5'd0,  8'd200);
    send_word(ACT_FIRE,   6'd1,  5'd0,  8'd0);    // place 0 clamps at the ceiling, place 19 reaches it
    send_word(ACT_READ,   6'd0,  5'd0,  8'd0);
    send_word(ACT_READ,   6'd0,  5'd19, 8'd0);
    send_word(ACT_FIRE,   6'd40, 5'd0,  8'd0);    // transition past the end
    send_word(ACT_FIRE,   6'd63, 5'd31, 8'd255);
    send_word(ACT_WR_IN,  6'd63, 5'd5,  8'd255);  // ignored writes, still write-done
    send_word(ACT_WR_OUT, 6'd39, 5'd31, 8'd255);
    send_word(ACT_SET,    6'd0,  5'd31, 8'd255);
    send_word(ACT_READ,   6'd0,  5'd31, 8'd0);    // place past the end reads zero
    send_word(ACT_READ + 3'd1, 6'd0,  5'd0,  8'd0);
    send_word(ACT_READ + 3'd2, 6'd21, 5'd10, 8'd85);
    send_word(ACT_READ + 3'd3, 6'd63, 5'd31, 8'd255);
    send_word(ACT_WR_IN,  6'd39, 5'd19, 8'd255);  // last transition, last place
    send_word(ACT_FIRE,   6'd39, 5'd0,  8'd0);    // enabled: place 19 holds exactly 255
    send_word(ACT_READ,   6'd0,  5'd19, 8'd0);
    send_word(ACT_SET,    6'd0,  5'd16, 8'd170);
    send_word(ACT_READ,   6'd0,  5'd16, 8'd0);

    // Random part: mostly programmed scenarios, some noise, calm stretches in between.
    while (useful_words < TARGET_WORDS) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      if ($urandom_range(0, 99) < 75) net_sequence();
      else repeat ($urandom_range(1, 6)) random_word();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d request words: %0d fires taken, %0d fires blocked,",
             sb.words_seen, sb.fires_taken, sb.fires_blocked);
    $display("%0d token reads, %0d writes; %0d mismatches seen.",
             sb.reads, sb.writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pnt_pkg.sv
hdl/pnt_ram.sv
hdl/pnt_alu.sv
hdl/petri_net_transition_firing_top.sv
sim/petri_net_transition_firing_top_tb.sv
